/* src/fme_pkg.sv */
// ----------------------------------------------------------------------------
// fme_pkg
// Shared types and constants for the fuzzy membership evaluator.
// ----------------------------------------------------------------------------
package fme_pkg;

   // default sizes
   localparam int DATA_WIDTH_DEF    = 16;
   localparam int FRACTION_BITS_DEF = 15;

   // configuration port
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REG_IDX_WIDTH  = 3;

   // register indexes (byte address = 4 * index)
   localparam logic [REG_IDX_WIDTH-1:0] REG_SHAPE          = 3'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_LEFT_FOOT      = 3'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_LEFT_SHOULDER  = 3'd2;
   localparam logic [REG_IDX_WIDTH-1:0] REG_RIGHT_SHOULDER = 3'd3;
   localparam logic [REG_IDX_WIDTH-1:0] REG_RIGHT_FOOT     = 3'd4;

   // shape codes
   localparam logic [1:0] SHAPE_TRIANGLE = 2'd0;
   localparam logic [1:0] SHAPE_GAMMA    = 2'd1;
   localparam logic [1:0] SHAPE_L        = 2'd2;
   localparam logic [1:0] SHAPE_TRAPEZE  = 2'd3;

   // how the final degree is formed from the quotient
   typedef enum logic [1:0] {
      MODE_RAMP = 2'd0,   // degree = quotient
      MODE_INV  = 2'd1,   // degree = 1.0 - quotient
      MODE_ZERO = 2'd2,   // degree = 0.0
      MODE_ONE  = 2'd3    // degree = 1.0
   } mode_type;

endpackage

/* src/fuzzy_membership_evaluator_top.sv */
// ----------------------------------------------------------------------------
// fuzzy_membership_evaluator_top
// Fuzzifier: membership degree of a signed sample for a configured shape.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_: one signed sample per item (req_valid / req_stall).
//   Result channel rsp_: one degree per item, unsigned with FRACTION_BITS
//   fraction bits (1.0 = 2**FRACTION_BITS), clamped to 0 .. 1.0.
//   Configuration through the csr_ APB port: shape, left_foot,
//   left_shoulder, right_shoulder, right_foot at byte addresses 0..16.
//   Write only while no item is in flight. Reads return register values.
// Pipeline:
//   One segment-select stage, one division cell per quotient bit and one
//   output register. Throughput is one item per cycle while rsp_stall is low;
//   the chain of division cells is fully pipelined.
// Reset: synchronous; empties the pipeline and clears the configuration registers to 0.
// Stall: a held result stays on rsp_ ports; cells behind it keep moving
//   into empty slots, and req_stall rises only once every stage is full.
// ----------------------------------------------------------------------------
module fuzzy_membership_evaluator_top #(
   parameter int DATA_WIDTH    = fme_pkg::DATA_WIDTH_DEF,
   parameter int FRACTION_BITS = fme_pkg::FRACTION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [DATA_WIDTH-1:0]        req_sample,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [FRACTION_BITS:0]              rsp_degree,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fme_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [fme_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [fme_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import fme_pkg::*;

   localparam logic [FRACTION_BITS:0] ONE_VALUE = {1'b1, {FRACTION_BITS{1'b0}}};

   // configuration registers
   logic [1:0]                   shape_ff;
   logic signed [DATA_WIDTH-1:0] left_foot_ff;
   logic signed [DATA_WIDTH-1:0] left_shoulder_ff;
   logic signed [DATA_WIDTH-1:0] right_shoulder_ff;
   logic signed [DATA_WIDTH-1:0] right_foot_ff;

   logic                     csr_write;
   logic [REG_IDX_WIDTH-1:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff          <= '0;
         left_foot_ff      <= '0;
         left_shoulder_ff  <= '0;
         right_shoulder_ff <= '0;
         right_foot_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SHAPE:          shape_ff          <= csr_pwdata[1:0];
            REG_LEFT_FOOT:      left_foot_ff      <= csr_pwdata[DATA_WIDTH-1:0];
            REG_LEFT_SHOULDER:  left_shoulder_ff  <= csr_pwdata[DATA_WIDTH-1:0];
            REG_RIGHT_SHOULDER: right_shoulder_ff <= csr_pwdata[DATA_WIDTH-1:0];
            REG_RIGHT_FOOT:     right_foot_ff     <= csr_pwdata[DATA_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_SHAPE:          csr_prdata[1:0]            = shape_ff;
         REG_LEFT_FOOT:      csr_prdata[DATA_WIDTH-1:0] = left_foot_ff;
         REG_LEFT_SHOULDER:  csr_prdata[DATA_WIDTH-1:0] = left_shoulder_ff;
         REG_RIGHT_SHOULDER: csr_prdata[DATA_WIDTH-1:0] = right_shoulder_ff;
         REG_RIGHT_FOOT:     csr_prdata[DATA_WIDTH-1:0] = right_foot_ff;
         default:            csr_prdata = '0;
      endcase
   end

   // links between stages: index 0 is the segment stage output
   logic [FRACTION_BITS:0]   link_valid;
   logic [FRACTION_BITS:0]   link_ready;
   logic [DATA_WIDTH-1:0]    link_rem [FRACTION_BITS+1];
   logic [DATA_WIDTH-1:0]    link_den [FRACTION_BITS+1];
   logic [FRACTION_BITS-1:0] link_quo [FRACTION_BITS+1];
   mode_type                 link_mode[FRACTION_BITS+1];
   logic                     seg_in_ready;

   assign req_stall   = !seg_in_ready;
   assign link_quo[0] = '0;

   fme_seg #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_seg (
      .clock          (clock),
      .reset          (reset),
      .shape          (shape_ff),
      .left_foot      (left_foot_ff),
      .left_shoulder  (left_shoulder_ff),
      .right_shoulder (right_shoulder_ff),
      .right_foot     (right_foot_ff),
      .in_valid       (req_valid),
      .in_ready       (seg_in_ready),
      .sample         (req_sample),
      .out_valid      (link_valid[0]),
      .out_ready      (link_ready[0]),
      .out_rem        (link_rem[0]),
      .out_den        (link_den[0]),
      .out_mode       (link_mode[0])
   );

   // chain of division cells, one quotient bit each
   for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_cell
      fme_div_cell #(
         .DATA_WIDTH    (DATA_WIDTH),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_rem    (link_rem[i]),
         .in_den    (link_den[i]),
         .in_quo    (link_quo[i]),
         .in_mode   (link_mode[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_rem   (link_rem[i+1]),
         .out_den   (link_den[i+1]),
         .out_quo   (link_quo[i+1]),
         .out_mode  (link_mode[i+1])
      );
   end

   // output register
   logic                   rsp_valid_ff;
   logic [FRACTION_BITS:0] rsp_degree_ff, rsp_degree_in;
   logic                   out_ready;
   logic [FRACTION_BITS:0] quo_ext;

   assign out_ready                = !rsp_valid_ff || !rsp_stall;
   assign link_ready[FRACTION_BITS] = out_ready;
   assign quo_ext                  = {1'b0, link_quo[FRACTION_BITS]};

   always_comb begin
      unique case (link_mode[FRACTION_BITS])
         MODE_RAMP: rsp_degree_in = quo_ext;
         MODE_INV:  rsp_degree_in = ONE_VALUE - quo_ext;
         MODE_ZERO: rsp_degree_in = '0;
         MODE_ONE:  rsp_degree_in = ONE_VALUE;
         default:   rsp_degree_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= link_valid[FRACTION_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && link_valid[FRACTION_BITS]) begin
         rsp_degree_ff <= rsp_degree_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_degree = rsp_degree_ff;

   // degree never exceeds 1.0
   a_degree_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_degree_ff <= ONE_VALUE))
      else $error("degree above 1.0");

   // input is held off only when every stage is full and the output blocked
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && (&link_valid)))
      else $error("input stalled with a free stage");

   // shape register takes the written value
   a_shape_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_index == REG_SHAPE)) |=> (shape_ff == $past(csr_pwdata[1:0])))
      else $error("shape write lost");

endmodule

/* src/fme_seg.sv */
// ----------------------------------------------------------------------------
// fme_seg
// Segment select: compares the sample against the breakpoints and registers
// the ramp numerator, denominator and output mode for the divider chain.
// ----------------------------------------------------------------------------
module fme_seg #(
   parameter int DATA_WIDTH = fme_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   shape,
   input  logic signed [DATA_WIDTH-1:0] left_foot,
   input  logic signed [DATA_WIDTH-1:0] left_shoulder,
   input  logic signed [DATA_WIDTH-1:0] right_shoulder,
   input  logic signed [DATA_WIDTH-1:0] right_foot,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [DATA_WIDTH-1:0] sample,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [DATA_WIDTH-1:0]        out_rem,
   output logic [DATA_WIDTH-1:0]        out_den,
   output fme_pkg::mode_type            out_mode
);
   import fme_pkg::*;

   localparam int EW = DATA_WIDTH + 1;

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] den_ff, den_in;
   mode_type              mode_ff, mode_in;

   logic signed [EW-1:0] x_ext, a_ext, m_ext, c_ext, e_ext;
   logic signed [EW-1:0] num_sel, den_sel;
   logic                 le_a, gt_e, le_m, lt_m, le_c;
   logic                 num_pos, den_pos;
   mode_type             seg_mode;

   // breakpoint compares and differences, one bit wider than the data
   always_comb begin
      x_ext = {sample[DATA_WIDTH-1], sample};
      a_ext = {left_foot[DATA_WIDTH-1], left_foot};
      m_ext = {left_shoulder[DATA_WIDTH-1], left_shoulder};
      c_ext = {right_shoulder[DATA_WIDTH-1], right_shoulder};
      e_ext = {right_foot[DATA_WIDTH-1], right_foot};
      le_a  = (sample <= left_foot);
      gt_e  = (sample > right_foot);
      le_m  = (sample <= left_shoulder);
      lt_m  = (sample < left_shoulder);
      le_c  = (sample <= right_shoulder);
   end

   // segment choice per shape
   always_comb begin
      seg_mode = MODE_ZERO;
      num_sel  = x_ext - a_ext;
      den_sel  = m_ext - a_ext;
      unique case (shape)
         SHAPE_TRIANGLE: begin
            if (le_a || gt_e) begin
               seg_mode = MODE_ZERO;
            end else if (le_m) begin
               seg_mode = MODE_RAMP;
            end else begin
               seg_mode = MODE_RAMP;
               num_sel  = e_ext - x_ext;
               den_sel  = e_ext - m_ext;
            end
         end
         SHAPE_GAMMA: begin
            if (le_a) begin
               seg_mode = MODE_ZERO;
            end else if (lt_m) begin
               seg_mode = MODE_RAMP;
            end else begin
               seg_mode = MODE_ONE;
            end
         end
         SHAPE_L: begin
            if (le_a) begin
               seg_mode = MODE_ONE;
            end else if (lt_m) begin
               seg_mode = MODE_INV;
            end else begin
               seg_mode = MODE_ZERO;
            end
         end
         SHAPE_TRAPEZE: begin
            if (le_a || gt_e) begin
               seg_mode = MODE_ZERO;
            end else if (le_m) begin
               seg_mode = MODE_RAMP;
            end else if (le_c) begin
               seg_mode = MODE_ONE;
            end else begin
               seg_mode = MODE_RAMP;
               num_sel  = e_ext - x_ext;
               den_sel  = e_ext - c_ext;
            end
         end
         default: seg_mode = MODE_ZERO;
      endcase
   end

   // ramp corner cases: empty ramp takes quotient 0, full ramp clamps quotient to 1.0
   always_comb begin
      num_pos = !num_sel[EW-1] && (num_sel != '0);
      den_pos = !den_sel[EW-1] && (den_sel != '0);
      mode_in = seg_mode;
      rem_in  = num_sel[DATA_WIDTH-1:0];
      den_in  = den_sel[DATA_WIDTH-1:0];
      if ((seg_mode == MODE_RAMP) || (seg_mode == MODE_INV)) begin
         if (!num_pos || !den_pos) begin
            mode_in = (seg_mode == MODE_RAMP) ? MODE_ZERO : MODE_ONE;
         end else if (num_sel >= den_sel) begin
            mode_in = (seg_mode == MODE_RAMP) ? MODE_ONE : MODE_ZERO;
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_mode  = mode_ff;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rem_ff  <= rem_in;
         den_ff  <= den_in;
         mode_ff <= mode_in;
      end
   end

endmodule

/* src/fme_div_cell.sv */
// ----------------------------------------------------------------------------
// fme_div_cell
// One restoring-division cell: produces one quotient bit per item and hands
// remainder, divisor and partial quotient to the next cell.
// ----------------------------------------------------------------------------
module fme_div_cell #(
   parameter int DATA_WIDTH    = fme_pkg::DATA_WIDTH_DEF,
   parameter int FRACTION_BITS = fme_pkg::FRACTION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [DATA_WIDTH-1:0]    in_rem,
   input  logic [DATA_WIDTH-1:0]    in_den,
   input  logic [FRACTION_BITS-1:0] in_quo,
   input  fme_pkg::mode_type        in_mode,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [DATA_WIDTH-1:0]    out_rem,
   output logic [DATA_WIDTH-1:0]    out_den,
   output logic [FRACTION_BITS-1:0] out_quo,
   output fme_pkg::mode_type        out_mode
);
   import fme_pkg::*;

   logic                     valid_ff;
   logic [DATA_WIDTH-1:0]    rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]    den_ff;
   logic [FRACTION_BITS-1:0] quo_ff, quo_in;
   mode_type                 mode_ff;

   logic [DATA_WIDTH:0] rem_dbl;
   logic [DATA_WIDTH:0] den_ext;
   logic [DATA_WIDTH:0] diff;
   logic                q_bit;

   // shift remainder, trial subtract (remainder stays below divisor)
   always_comb begin
      rem_dbl = {in_rem, 1'b0};
      den_ext = {1'b0, in_den};
      diff    = rem_dbl - den_ext;
      q_bit   = (rem_dbl >= den_ext);
      rem_in  = q_bit ? diff[DATA_WIDTH-1:0] : rem_dbl[DATA_WIDTH-1:0];
      quo_in  = {in_quo[FRACTION_BITS-2:0], q_bit};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_mode  = mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         quo_ff  <= quo_in;
         mode_ff <= in_mode;
      end
   end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fuzzy_membership_evaluator_top. Programs each
// membership shape over the APB port, streams signed samples through the
// valid/stall channels with random gaps and receiver hold-offs, and compares
// every returned degree against a behavioral model of the fuzzifier or a directed value.
// ----------------------------------------------------------------------------
module testbench;
   import fme_pkg::*;

   localparam int DW            = DATA_WIDTH_DEF;
   localparam int FB            = FRACTION_BITS_DEF;
   localparam longint UNITY     = longint'(1) << FB;
   localparam int PIPE_LATENCY  = FB + 2;
   localparam int QUIET_LIMIT   = 3000;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_SETUPS = 20;
   localparam int ITEMS_PER_SET = 80;
   localparam int HOLD_SETUP    = 6;
   localparam int PAUSE_SETUP   = 9;
   localparam int CALM_SETUPS   = 3;
   localparam int MAX_REPORTS   = 10;
   localparam int NO_WANT       = -1;
   localparam int NUM_DIRECTED  = 26;

   // register image as the block should hold it
   typedef struct packed {
      logic [1:0]    shape;
      logic [DW-1:0] left_foot;
      logic [DW-1:0] left_shoulder;
      logic [DW-1:0] right_shoulder;
      logic [DW-1:0] right_foot;
   } shape_setup_type;

   // directed row: setup, sample, and the degree when it is obvious
   typedef struct {
      int shape;
      int a;
      int m;
      int c;
      int e;
      int x;
      int want;
   } directed_row_type;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      // reset setup: triangle collapsed to a point
      '{SHAPE_TRIANGLE, 0, 0, 0, 0, 0, 0},
      '{SHAPE_TRIANGLE, 0, 0, 0, 0, 32767, 0},
      '{SHAPE_TRIANGLE, 0, 0, 0, 0, -32768, 0},
      // ordinary triangle
      '{SHAPE_TRIANGLE, -100, 0, 0, 100, -50, 16384},
      '{SHAPE_TRIANGLE, -100, 0, 0, 100, 0, 32768},
      '{SHAPE_TRIANGLE, -100, 0, 0, 100, 50, 16384},
      '{SHAPE_TRIANGLE, -100, 0, 0, 100, 100, 0},
      // triangle spanning the full sample range
      '{SHAPE_TRIANGLE, -32768, 0, 0, 32767, -32767, NO_WANT},
      '{SHAPE_TRIANGLE, -32768, 0, 0, 32767, 32767, 0},
      '{SHAPE_TRIANGLE, -32768, 0, 0, 32767, -1, NO_WANT},
      // gamma with widest ramp
      '{SHAPE_GAMMA, -32768, 32767, 0, 0, 32766, NO_WANT},
      '{SHAPE_GAMMA, -32768, 32767, 0, 0, 32767, 32768},
      '{SHAPE_GAMMA, -32768, 32767, 0, 0, -32768, 0},
      // L shape, ordinary then with peak below foot
      '{SHAPE_L, 0, 10, 0, 0, 0, 32768},
      '{SHAPE_L, 0, 10, 0, 0, 5, NO_WANT},
      '{SHAPE_L, 0, 10, 0, 0, 10, 0},
      '{SHAPE_L, 10, 0, 0, 0, 5, 32768},
      '{SHAPE_L, 10, 0, 0, 0, 20, 0},
      // trapezoid, ordinary
      '{SHAPE_TRAPEZE, -200, -100, 100, 200, -150, NO_WANT},
      '{SHAPE_TRAPEZE, -200, -100, 100, 200, 0, 32768},
      '{SHAPE_TRAPEZE, -200, -100, 100, 200, 150, NO_WANT},
      '{SHAPE_TRAPEZE, -200, -100, 100, 200, 201, 0},
      // degenerate breakpoints: all equal, shoulder below foot
      '{SHAPE_TRAPEZE, 5, 5, 5, 5, 6, 0},
      '{SHAPE_TRAPEZE, 0, -10, 10, 20, 5, 32768},
      '{SHAPE_TRAPEZE, 0, -10, 10, 20, 15, NO_WANT},
      // triangle with peak beyond the end
      '{SHAPE_TRIANGLE, 0, 100, 0, 50, 30, NO_WANT}
   };

   logic                      clock;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   logic [DW-1:0]             req_sample  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   logic [FB:0]               rsp_degree;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   shape_setup_type live_setup = '0;
   logic [FB:0]  expected_degrees [$];
   logic         gaps_on        = 1'b0;
   int           hold_requests  = 0;
   int           holds_served   = 0;
   int           hold_left      = 0;
   int           quiet_cycles   = 0;
   int           mismatch_count = 0;
   int           samples_sent   = 0;
   int           degrees_seen   = 0;
   int           setups_loaded  = 0;

   fuzzy_membership_evaluator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_degree  (rsp_degree),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // (num << FB) / den, truncated and capped at UNITY; non-positive terms give zero
   function automatic longint ramp_fraction(input longint num, input longint den);
      longint q;
      if (den <= 0 || num <= 0)
         return 0;
      q = (num <<< FB) / den;
      return (q > UNITY) ? UNITY : q;
   endfunction

   // membership degree of one sample under a given setup
   function automatic logic [FB:0] membership_degree(input shape_setup_type s,
                                                     input logic [DW-1:0] raw);
      longint x, a, m, c, e, u;
      x = $signed(raw);
      a = $signed(s.left_foot);
      m = $signed(s.left_shoulder);
      c = $signed(s.right_shoulder);
      e = $signed(s.right_foot);
      case (s.shape)
         SHAPE_TRIANGLE: begin
            if (x <= a || x > e)
               u = 0;
            else if (x <= m)
               u = ramp_fraction(x - a, m - a);
            else
               u = ramp_fraction(e - x, e - m);
         end
         SHAPE_GAMMA: begin
            if (x <= a)
               u = 0;
            else if (x < m)
               u = ramp_fraction(x - a, m - a);
            else
               u = UNITY;
         end
         SHAPE_L: begin
            if (x <= a)
               u = UNITY;
            else if (x < m)
               u = UNITY - ramp_fraction(x - a, m - a);
            else
               u = 0;
         end
         default: begin
            if (x <= a || x > e)
               u = 0;
            else if (x <= m)
               u = ramp_fraction(x - a, m - a);
            else if (x <= c)
               u = UNITY;
            else
               u = ramp_fraction(e - x, e - c);
         end
      endcase
      if (u > UNITY)
         u = UNITY;
      return u[FB:0];
   endfunction

   // one APB write; leaves psel high so writes can run back to back
   task automatic write_register(input logic [REG_IDX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_SHAPE:          live_setup.shape          = data[1:0];
         REG_LEFT_FOOT:      live_setup.left_foot      = data[DW-1:0];
         REG_LEFT_SHOULDER:  live_setup.left_shoulder  = data[DW-1:0];
         REG_RIGHT_SHOULDER: live_setup.right_shoulder = data[DW-1:0];
         REG_RIGHT_FOOT:     live_setup.right_foot     = data[DW-1:0];
         default: ;
      endcase
   endtask

   // program a whole setup; upper data bits are junk, plus one stray index
   task automatic load_setup(input shape_setup_type s);
      write_register(REG_SHAPE, {30'($urandom), s.shape});
      write_register(REG_LEFT_FOOT, {16'($urandom), s.left_foot});
      write_register(REG_LEFT_SHOULDER, {16'($urandom), s.left_shoulder});
      write_register(REG_RIGHT_SHOULDER, {16'($urandom), s.right_shoulder});
      write_register(REG_RIGHT_FOOT, {16'($urandom), s.right_foot});
      write_register(3'(REG_RIGHT_FOOT + 1 + $urandom_range(0, 2)), $urandom);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      setups_loaded++;
   endtask

   // offer one sample, record its degree once it is taken
   task automatic send_sample(input logic [DW-1:0] s, input int want);
      logic [FB:0] deg;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      deg = (want == NO_WANT) ? membership_degree(live_setup, s) : want[FB:0];
      do @(posedge clock); while (req_stall);
      expected_degrees.push_back(deg);
      samples_sent++;
   endtask

   // stop offering and wait for every outstanding degree
   task automatic finish_items();
      req_valid <= 1'b0;
      while (expected_degrees.size() != 0)
         @(posedge clock);
   endtask

   task automatic report_mismatch(input logic [FB:0] want, input logic [FB:0] got,
                                  input bit orphan);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         if (orphan)
            $display("mismatch: degree %0d arrived with none outstanding", got);
         else
            $display("mismatch: degree %0d expected, %0d received (result %0d)",
                     want, got, degrees_seen);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_degrees.size() == 0)
            report_mismatch('0, rsp_degree, 1'b1);
         else if (rsp_degree !== expected_degrees[0])
            report_mismatch(expected_degrees[0], rsp_degree, 1'b0);
         if (expected_degrees.size() != 0)
            void'(expected_degrees.pop_front());
         degrees_seen++;
      end
   end

   // receiver: long hold-off on request, else random stall bursts
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served <= holds_served + 1;
         hold_left    <= LONG_HOLD - 1;
         rsp_stall    <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         hold_left <= $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
         $display("testbench failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      directed_row_type row;
      shape_setup_type  next_setup;
      int            pts [4];
      int            kind, tmp, lo, hi, span, x;
      logic          gaps_next;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows; reprogram only when the setup changes
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = directed_rows[i];
         next_setup.shape          = 2'(row.shape);
         next_setup.left_foot      = DW'(row.a);
         next_setup.left_shoulder  = DW'(row.m);
         next_setup.right_shoulder = DW'(row.c);
         next_setup.right_foot     = DW'(row.e);
         if (next_setup != live_setup) begin
            finish_items();
            load_setup(next_setup);
         end
         send_sample(DW'(row.x), row.want);
      end
      finish_items();

      // random setups, each followed by a burst of samples
      for (int phase = 0; phase < RANDOM_SETUPS; phase++) begin
         for (int k = 0; k < 4; k++)
            pts[k] = int'($urandom_range(0, 65535)) - 32768;
         case ($urandom_range(1, 8))
            1, 2, 3: kind = 1;   // ordered, wide
            4, 5, 6: kind = 2;   // ordered, narrow
            7:       kind = 3;   // unordered
            default: kind = 4;   // all points equal
         endcase
         if (phase == 0)
            kind = 0;            // full-range extremes
         if (kind == 2) begin
            for (int k = 1; k < 4; k++) begin
               pts[k] = pts[k-1] + int'($urandom_range(0, 400));
               if (pts[k] > 32767)
                  pts[k] = 32767;
            end
         end
         if (kind == 4)
            for (int k = 1; k < 4; k++)
               pts[k] = pts[0];
         if (kind != 3) begin
            for (int p = 0; p < 3; p++)
               for (int k = 0; k < 3 - p; k++)
                  if (pts[k] > pts[k+1]) begin
                     tmp      = pts[k];
                     pts[k]   = pts[k+1];
                     pts[k+1] = tmp;
                  end
         end
         if (kind == 0) begin
            pts[0] = -32768;
            pts[3] = 32767;
         end
         next_setup.shape          = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
         next_setup.left_foot      = DW'(pts[0]);
         next_setup.left_shoulder  = DW'(pts[1]);
         next_setup.right_shoulder = DW'(pts[2]);
         next_setup.right_foot     = DW'(pts[3]);
         load_setup(next_setup);

         lo = pts[0];
         hi = pts[0];
         for (int k = 1; k < 4; k++) begin
            if (pts[k] < lo) lo = pts[k];
            if (pts[k] > hi) hi = pts[k];
         end
         span = hi - lo;

         // no idling in the closing setups or while the receiver holds off
         gaps_next = (phase < RANDOM_SETUPS - CALM_SETUPS) && (phase != HOLD_SETUP) &&
                     ($urandom_range(0, 3) != 0);
         gaps_on <= gaps_next;
         if (phase == HOLD_SETUP)
            hold_requests <= hold_requests + 1;

         for (int n = 0; n < ITEMS_PER_SET; n++) begin
            if (phase == PAUSE_SETUP && n == ITEMS_PER_SET / 2)
               finish_items();
            case ($urandom_range(0, 7))
               0:       x = int'($urandom_range(0, 65535)) - 32768;
               1:       x = pts[$urandom_range(0, 3)] + int'($urandom_range(0, 2)) - 1;
               default: x = lo - span / 4 - 2 + int'($urandom_range(0, span + span / 2 + 4));
            endcase
            if (x > 32767)  x = 32767;
            if (x < -32768) x = -32768;
            send_sample(DW'(x), NO_WANT);
         end
         finish_items();
      end

      gaps_on <= 1'b0;
      repeat (PIPE_LATENCY + 4) @(posedge clock);

      $display("covered %0d samples across %0d setups (all four shapes, full-range",
               samples_sent, setups_loaded);
      $display("and degenerate breakpoints, long hold-off); %0d degrees checked, %0d bad",
               degrees_seen, mismatch_count);
      if (expected_degrees.size() != 0)
         $display("%0d degrees never arrived", expected_degrees.size());
      if (mismatch_count == 0 && expected_degrees.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
